[hdl/owm_pkg.sv]
// Shared types and constants for the one-wire bus master.
// No dependencies; compiled first.
package owm_pkg;

  localparam int TickW    = 10;
  localparam int LimitW   = 8;
  localparam int CfgDataW = 10;
  localparam int CfgIdxW  = 3;

  localparam logic [7:0]       SkipRomCode = 8'hCC;
  localparam logic [TickW-1:0] ResetLowDefault   = 10'd504;
  localparam logic [LimitW-1:0] PresStartDefault = 8'd120;
  localparam logic [LimitW-1:0] PresEndDefault   = 8'd240;
  localparam logic [TickW-1:0] RecoveryDefault   = 10'd430;
  localparam logic [LimitW-1:0] SlotHoldDefault  = 8'd63;

  localparam logic [TickW:0] WLowTicks = 11'd5;
  localparam logic [TickW:0] WRecTicks = 11'd2;
  localparam logic [TickW:0] RLowTicks = 11'd6;
  localparam logic [TickW:0] RRelTicks = 11'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RESET_LOW   = 3'd0,
    CFG_PRES_START  = 3'd1,
    CFG_PRES_END    = 3'd2,
    CFG_RECOVERY    = 3'd3,
    CFG_SLOT_HOLD   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_PRES    = 2'd1,
    ST_STUCK_LOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       line_level;
  } cmd_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
  } res_t;

endpackage

[hdl/owm_chan_if.sv]
// Valid/ready channel interface carrying one payload item per transfer.
// The payload type is a parameter; the block uses the structs of owm_pkg.
interface owm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hdl/onewire_bus_master.sv]
// One-wire bus master: tick-driven reset/presence, byte write and byte read sequencer.
// Depends on owm_pkg and the owm_chan_if channel interface.
//
//   channel | direction | payload                                    | transfer when
//   cmd     | in        | kind, data_byte, line_level                | cmd.valid && cmd.ready
//   res     | out       | drive_low, busy_res, done_res, status,     | res.valid && res.ready
//           |           | read_data                                  |
//   cfg     | in        | cfg_index, cfg_data                        | cfg_we
//
// Every command transfer is one bus tick and yields exactly one result transfer.
// A tick is evaluated in the cycle it is accepted and its result sits in the output
// register from the next cycle on, so one tick per clock is sustained unless res.ready is low;
// the figure is set by the single state update between the accept and the output register.
// While a result waits, a new tick is still taken in the same cycle the result leaves.
// Reset (rst, synchronous) returns the sequencer to idle, clears all counters and
// restores the default timing registers; no result is pending after reset.
module onewire_bus_master (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [owm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [owm_pkg::CfgDataW-1:0] cfg_data,
  owm_chan_if.sink                 cmd,
  owm_chan_if.source               res
);
  import owm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_PRES_WAIT = 4'd2,
    PH_PRES_END  = 4'd3,
    PH_RECOVER   = 4'd4,
    PH_W_LOW     = 4'd5,
    PH_W_HOLD    = 4'd6,
    PH_W_REC     = 4'd7,
    PH_R_LOW     = 4'd8,
    PH_R_REL     = 4'd9,
    PH_R_HOLD    = 4'd10
  } phase_t;

  // Timing registers.
  logic [TickW-1:0]  reset_low_ticks;
  logic [LimitW-1:0] presence_start_limit;
  logic [LimitW-1:0] presence_end_limit;
  logic [TickW-1:0]  recovery_ticks;
  logic [LimitW-1:0] slot_hold_ticks;

  // Sequencer state.
  phase_t           phase, phase_next;
  logic [TickW-1:0] tick_count, tick_count_next;
  logic [2:0]       bit_index, bit_index_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [1:0]       last_status, last_status_next;
  logic [7:0]       read_result, read_result_next;

  // Output register.
  logic res_valid;
  res_t res_data, res_data_next;

  cmd_t cmd_item;
  logic accept;

  assign cmd_item  = cmd.payload;
  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign res.valid = res_valid;
  assign res.payload = res_data;

  // True when the current tick is the last one of a phase of length len
  // (a length of zero behaves as one).
  function automatic logic last_tick(input logic [TickW-1:0] cnt, input logic [TickW:0] len);
    last_tick = ({1'b0, cnt} + 11'd1) >= len;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_ticks      <= ResetLowDefault;
      presence_start_limit <= PresStartDefault;
      presence_end_limit   <= PresEndDefault;
      recovery_ticks       <= RecoveryDefault;
      slot_hold_ticks      <= SlotHoldDefault;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESET_LOW:  reset_low_ticks      <= cfg_data;
        CFG_PRES_START: presence_start_limit <= cfg_data[LimitW-1:0];
        CFG_PRES_END:   presence_end_limit   <= cfg_data[LimitW-1:0];
        CFG_RECOVERY:   recovery_ticks       <= cfg_data;
        CFG_SLOT_HOLD:  slot_hold_ticks      <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // One bus tick: optional command start, then one step of the current phase.
  always_comb begin
    logic drive;
    logic done;
    logic busy;
    logic over;
    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    shift_byte_next  = shift_byte;
    last_status_next = last_status;
    read_result_next = read_result;
    drive = 1'b0;
    done  = 1'b0;
    over  = 1'b0;

    if (phase == PH_IDLE) begin
      unique case (cmd_item.kind)
        KIND_RESET: begin
          phase_next      = PH_RST_LOW;
          tick_count_next = '0;
        end
        KIND_WRITE: begin
          phase_next      = PH_W_LOW;
          shift_byte_next = cmd_item.data_byte;
          bit_index_next  = '0;
          tick_count_next = '0;
        end
        KIND_READ: begin
          phase_next      = PH_R_LOW;
          shift_byte_next = '0;
          bit_index_next  = '0;
          tick_count_next = '0;
        end
        default: ;
      endcase
    end
    busy = (phase_next != PH_IDLE);

    unique case (phase_next)
      PH_IDLE: ;
      PH_RST_LOW: begin
        drive = 1'b1;
        over  = last_tick(tick_count_next, {1'b0, reset_low_ticks});
        tick_count_next = over ? '0 : tick_count_next + 10'd1;
        if (over) phase_next = PH_PRES_WAIT;
      end
      PH_PRES_WAIT: begin
        if (!cmd_item.line_level) begin
          tick_count_next = '0;
          phase_next      = PH_PRES_END;
        end else if (tick_count_next > {2'b00, presence_start_limit}) begin
          last_status_next = ST_NO_PRES;
          done             = 1'b1;
          tick_count_next  = '0;
          phase_next       = PH_IDLE;
        end else begin
          tick_count_next = tick_count_next + 10'd1;
        end
      end
      PH_PRES_END: begin
        if (cmd_item.line_level) begin
          last_status_next = ST_OK;
          tick_count_next  = '0;
          if (recovery_ticks == '0) begin
            phase_next      = PH_W_LOW;
            shift_byte_next = SkipRomCode;
            bit_index_next  = '0;
          end else begin
            phase_next = PH_RECOVER;
          end
        end else if (tick_count_next > {2'b00, presence_end_limit}) begin
          last_status_next = ST_STUCK_LOW;
          done             = 1'b1;
          tick_count_next  = '0;
          phase_next       = PH_IDLE;
        end else begin
          tick_count_next = tick_count_next + 10'd1;
        end
      end
      PH_RECOVER: begin
        over = last_tick(tick_count_next, {1'b0, recovery_ticks});
        tick_count_next = over ? '0 : tick_count_next + 10'd1;
        if (over) begin
          phase_next      = PH_W_LOW;
          shift_byte_next = SkipRomCode;
          bit_index_next  = '0;
        end
      end
      PH_W_LOW: begin
        drive = 1'b1;
        over  = last_tick(tick_count_next, WLowTicks);
        tick_count_next = over ? '0 : tick_count_next + 10'd1;
        if (over) phase_next = PH_W_HOLD;
      end
      PH_W_HOLD: begin
        drive = ~shift_byte_next[bit_index_next];
        over  = last_tick(tick_count_next, {3'b000, slot_hold_ticks});
        tick_count_next = over ? '0 : tick_count_next + 10'd1;
        if (over) phase_next = PH_W_REC;
      end
      PH_W_REC: begin
        over = last_tick(tick_count_next, WRecTicks);
        tick_count_next = over ? '0 : tick_count_next + 10'd1;
        if (over) begin
          if (bit_index_next == 3'd7) begin
            done           = 1'b1;
            bit_index_next = '0;
            phase_next     = PH_IDLE;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next     = PH_W_LOW;
          end
        end
      end
      PH_R_LOW: begin
        drive = 1'b1;
        over  = last_tick(tick_count_next, RLowTicks);
        tick_count_next = over ? '0 : tick_count_next + 10'd1;
        if (over) phase_next = PH_R_REL;
      end
      PH_R_REL: begin
        over = last_tick(tick_count_next, RRelTicks);
        tick_count_next = over ? '0 : tick_count_next + 10'd1;
        if (over) phase_next = PH_R_HOLD;
      end
      PH_R_HOLD: begin
        // The line is sampled on the first hold tick of the slot.
        if (tick_count_next == '0) begin
          shift_byte_next[bit_index_next] = shift_byte_next[bit_index_next] |
                                            cmd_item.line_level;
        end
        over = last_tick(tick_count_next, {3'b000, slot_hold_ticks});
        tick_count_next = over ? '0 : tick_count_next + 10'd1;
        if (over) begin
          if (bit_index_next == 3'd7) begin
            read_result_next = shift_byte_next;
            done             = 1'b1;
            bit_index_next   = '0;
            phase_next       = PH_IDLE;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next     = PH_R_LOW;
          end
        end
      end
      default: begin
        // Codes outside the sequence fall back to idle with the bus released.
        phase_next      = PH_IDLE;
        tick_count_next = '0;
        bit_index_next  = '0;
      end
    endcase

    res_data_next.drive_low = drive;
    res_data_next.busy_res  = busy;
    res_data_next.done_res  = done;
    res_data_next.status    = last_status_next;
    res_data_next.read_data = read_result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= '0;
      bit_index   <= '0;
      shift_byte  <= '0;
      last_status <= '0;
      read_result <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        tick_count  <= tick_count_next;
        bit_index   <= bit_index_next;
        shift_byte  <= shift_byte_next;
        last_status <= last_status_next;
        read_result <= read_result_next;
        res_valid   <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it only loads on an accepted tick.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data <= res_data_next;
    end
  end

endmodule

[hdl/owm_checker.sv]
// Port-level checks for the one-wire bus master, bound to its top level.
// Depends on onewire_bus_master and its channel ports.
module owm_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       drive_low,
  input logic       busy_res,
  input logic       done_res,
  input logic [12:0] res_bits
);

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A held result blocks the next tick.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !cmd_ready)
    else $error("tick accepted while result stalled");

  // The bus is only pulled low inside a command.
  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && drive_low) |-> busy_res)
    else $error("bus driven while idle");

  // A command finishes on a busy tick.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && done_res) |-> busy_res)
    else $error("done without busy");

  // A stalled result holds its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_bits)))
    else $error("stalled result changed");

endmodule

bind onewire_bus_master owm_checker u_owm_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .drive_low (res.payload.drive_low),
  .busy_res  (res.payload.busy_res),
  .done_res  (res.payload.done_res),
  .res_bits  (res.payload)
);
